>>> rtl/mlqm_pkg.sv
// Package for the multi-list queue manager: sizes, operation codes and the
// pointer and memory request types shared by the control and top-level files.
// Depends on nothing.
`timescale 1ns / 1ps

package mlqm_pkg;

  // Pool and list sizes.
  localparam int NUM_SLOTS  = 256;
  localparam int NUM_LISTS  = 5;

  // Fixed field widths of the item ports.
  localparam int KIND_W     = 2;
  localparam int LIST_W     = 3;
  localparam int SLOT_IN_W  = 8;

  // Derived internal widths.
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LIST_IW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int LINK_DEPTH = NUM_LISTS * NUM_SLOTS;
  localparam int LINK_AW    = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;

  // Operation codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    OP_ADD    = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // Slot pointer with a valid bit.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
  } ptr_t;

  localparam int PTR_W = $bits(ptr_t);

  // Request to one of the link memories.
  typedef struct packed {
    logic               we;
    logic [LINK_AW-1:0] waddr;
    ptr_t               wdata;
    logic [LINK_AW-1:0] raddr;
  } link_req_t;

  // Request to the membership memory.
  typedef struct packed {
    logic                 we;
    logic [SLOT_W-1:0]    waddr;
    logic [NUM_LISTS-1:0] wdata;
    logic [SLOT_W-1:0]    raddr;
  } mem_req_t;

endpackage

>>> rtl/mlqm_in_if.sv
// Request channel of the multi-list queue manager: valid, ready and one item.
// Depends on mlqm_pkg.
`timescale 1ns / 1ps

interface mlqm_in_if import mlqm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [LIST_W-1:0]    list_sel;
  logic [SLOT_IN_W-1:0] slot_index;

  modport source (output valid, kind, list_sel, slot_index, input ready);
  modport sink   (input valid, kind, list_sel, slot_index, output ready);
endinterface

>>> rtl/mlqm_out_if.sv
// Response channel of the multi-list queue manager: valid, ready and one item.
// Depends on mlqm_pkg.
`timescale 1ns / 1ps

interface mlqm_out_if import mlqm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 done_res;
  logic [SLOT_IN_W-1:0] popped_slot;

  modport source (output valid, done_res, popped_slot, input ready);
  modport sink   (input valid, done_res, popped_slot, output ready);
endinterface

>>> rtl/multi_list_queue_manager.sv
// Multi-list queue manager: one item passes the steps accept, memory read,
// update and result load before the block is ready again, and an add to a
// list that is not empty has a link step between update and result load,
// because the link memories have one write port each and a registered read,
// so the old tail's next link is written in a step of its own. A result waits
// in an output register and the block is ready again as soon as it is loaded
// there. Lists are empty right after reset; membership valid bits clear at once, so there is no clearing pass.
// Depends on mlqm_pkg, mlqm_in_if, mlqm_out_if, mlqm_ram and mlqm_ctrl.
`timescale 1ns / 1ps

module multi_list_queue_manager import mlqm_pkg::*; (
  input logic        clk,
  input logic        rst,
  mlqm_in_if.sink    req,
  mlqm_out_if.source rsp
);

  link_req_t            next_req;
  link_req_t            prev_req;
  mem_req_t             mem_req;
  ptr_t                 next_rdata;
  ptr_t                 prev_rdata;
  logic [NUM_LISTS-1:0] mem_rdata;

  // Next links, one per slot and list.
  mlqm_ram #(.DEPTH(LINK_DEPTH), .WIDTH(PTR_W)) u_next_ram (
    .clk   (clk),
    .we    (next_req.we),
    .waddr (next_req.waddr),
    .wdata (next_req.wdata),
    .raddr (next_req.raddr),
    .rdata (next_rdata)
  );

  // Previous links, one per slot and list.
  mlqm_ram #(.DEPTH(LINK_DEPTH), .WIDTH(PTR_W)) u_prev_ram (
    .clk   (clk),
    .we    (prev_req.we),
    .waddr (prev_req.waddr),
    .wdata (prev_req.wdata),
    .raddr (prev_req.raddr),
    .rdata (prev_rdata)
  );

  // Membership words, one bit per list for each slot.
  mlqm_ram #(.DEPTH(NUM_SLOTS), .WIDTH(NUM_LISTS)) u_member_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Operation sequencer.
  mlqm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .next_req   (next_req),
    .prev_req   (prev_req),
    .mem_req    (mem_req),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata),
    .mem_rdata  (mem_rdata)
  );

endmodule

>>> rtl/mlqm_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module mlqm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mlqm_ctrl.sv
// Sequencer of the multi-list queue manager: takes one item, reads the link
// and membership memories, then rewrites links, head, tail and membership.
// Depends on mlqm_pkg, mlqm_in_if and mlqm_out_if.
`timescale 1ns / 1ps

module mlqm_ctrl import mlqm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  mlqm_in_if.sink              req,
  mlqm_out_if.source           rsp,
  output link_req_t            next_req,
  output link_req_t            prev_req,
  output mem_req_t             mem_req,
  input  ptr_t                 next_rdata,
  input  ptr_t                 prev_rdata,
  input  logic [NUM_LISTS-1:0] mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_LINK,
    S_RESP
  } state_t;

  localparam ptr_t PTR_NULL = '0;

  // Flat link address of one slot on one list.
  function automatic logic [LINK_AW-1:0] link_addr(input logic [LIST_IW-1:0] l,
                                                   input logic [SLOT_W-1:0]  s);
    return LINK_AW'(LINK_AW'(l) * LINK_AW'(NUM_SLOTS) + LINK_AW'(s));
  endfunction

  state_t               state;
  op_t                  op;
  logic [LIST_IW-1:0]   lst;
  logic [SLOT_W-1:0]    slot;
  logic                 ok;
  logic                 mvalid_rd;
  ptr_t                 last_tail;
  logic                 res_done;
  logic [SLOT_W-1:0]    res_slot;
  logic                 out_valid;
  logic                 out_done;
  logic [SLOT_IN_W-1:0] out_slot;
  ptr_t                 head [NUM_LISTS];
  ptr_t                 tail [NUM_LISTS];
  logic [NUM_SLOTS-1:0] mvalid;

  ptr_t                 cur_head;
  ptr_t                 cur_tail;
  ptr_t                 me;
  logic [SLOT_W-1:0]    slot_sel;
  logic [NUM_LISTS-1:0] member_cur;
  logic [NUM_LISTS-1:0] bit_mask;
  logic                 is_mem;
  logic                 ex_done;
  logic                 head_we;
  ptr_t                 head_wd;
  logic                 tail_we;
  ptr_t                 tail_wd;
  logic                 list_ok;
  logic                 slot_ok;
  op_t                  req_op;

  // Range checks on the incoming item.
  assign req_op  = op_t'(req.kind);
  assign list_ok = (32'(req.list_sel) < NUM_LISTS);
  assign slot_ok = (32'(req.slot_index) < NUM_SLOTS);

  // Port drives.
  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.done_res    = out_done;
  assign rsp.popped_slot = out_slot;

  // Views of the current list and of the membership word read back.
  assign cur_head   = head[lst];
  assign cur_tail   = tail[lst];
  assign me         = '{valid: 1'b1, idx: slot};
  assign slot_sel   = (op == OP_POP) ? cur_head.idx : slot;
  assign member_cur = mvalid_rd ? mem_rdata : '0;
  assign bit_mask   = NUM_LISTS'(1) << lst;
  assign is_mem     = |(member_cur & bit_mask);

  // Memory requests and head/tail updates for each step of the sequence.
  always_comb begin
    next_req       = '0;
    prev_req       = '0;
    mem_req        = '0;
    next_req.raddr = link_addr(lst, slot_sel);
    prev_req.raddr = link_addr(lst, slot);
    mem_req.raddr  = slot_sel;
    head_we        = 1'b0;
    head_wd        = PTR_NULL;
    tail_we        = 1'b0;
    tail_wd        = PTR_NULL;
    ex_done        = 1'b0;
    case (state)
      S_EXEC: begin
        case (op)
          OP_ADD: begin
            if (ok && !is_mem) begin
              ex_done        = 1'b1;
              mem_req.we     = 1'b1;
              mem_req.waddr  = slot;
              mem_req.wdata  = member_cur | bit_mask;
              prev_req.we    = 1'b1;
              prev_req.waddr = link_addr(lst, slot);
              prev_req.wdata = cur_tail;
              next_req.we    = 1'b1;
              next_req.waddr = link_addr(lst, slot);
              next_req.wdata = PTR_NULL;
              if (!cur_tail.valid) begin
                head_we = 1'b1;
                head_wd = me;
              end
              tail_we = 1'b1;
              tail_wd = me;
            end
          end
          OP_POP: begin
            if (ok && cur_head.valid) begin
              ex_done       = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.waddr = cur_head.idx;
              mem_req.wdata = member_cur & ~bit_mask;
              head_we       = 1'b1;
              if (next_rdata.valid) begin
                head_wd        = next_rdata;
                prev_req.we    = 1'b1;
                prev_req.waddr = link_addr(lst, next_rdata.idx);
                prev_req.wdata = PTR_NULL;
              end else begin
                tail_we = 1'b1;
              end
            end
          end
          OP_REMOVE: begin
            if (ok && is_mem) begin
              ex_done       = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.waddr = slot;
              mem_req.wdata = member_cur & ~bit_mask;
              if (prev_rdata.valid) begin
                next_req.we    = 1'b1;
                next_req.waddr = link_addr(lst, prev_rdata.idx);
                next_req.wdata = next_rdata;
              end else begin
                head_we = 1'b1;
                head_wd = next_rdata;
              end
              if (next_rdata.valid) begin
                prev_req.we    = 1'b1;
                prev_req.waddr = link_addr(lst, next_rdata.idx);
                prev_req.wdata = prev_rdata;
              end else begin
                tail_we = 1'b1;
                tail_wd = prev_rdata;
              end
            end
          end
          default: begin
            ex_done = ok && cur_head.valid;
          end
        endcase
      end
      S_LINK: begin
        next_req.we    = 1'b1;
        next_req.waddr = link_addr(lst, last_tail.idx);
        next_req.wdata = me;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, list pointers, membership valid bits and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mvalid    <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        head[i].valid <= 1'b0;
        tail[i].valid <= 1'b0;
      end
    end else begin
      mvalid_rd <= mvalid[slot_sel];
      if (mem_req.we) begin
        mvalid[mem_req.waddr] <= 1'b1;
      end
      if (head_we) begin
        head[lst] <= head_wd;
      end
      if (tail_we) begin
        tail[lst] <= tail_wd;
      end
      // The result register loads a new item or empties once it is taken.
      if (state == S_RESP && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req_op;
            lst   <= list_ok ? LIST_IW'(req.list_sel) : '0;
            slot  <= SLOT_W'(req.slot_index);
            ok    <= list_ok && (slot_ok || req_op == OP_POP || req_op == OP_QUERY);
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          res_done  <= ex_done;
          res_slot  <= (op == OP_POP && ex_done) ? cur_head.idx : '0;
          last_tail <= cur_tail;
          if (op == OP_ADD && ex_done && cur_tail.valid) begin
            state <= S_LINK;
          end else begin
            state <= S_RESP;
          end
        end
        S_LINK: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_done <= res_done;
            out_slot <= SLOT_IN_W'(res_slot);
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> verif/multi_list_queue_manager_tb.sv
// Self-checking testbench for multi_list_queue_manager: a scoreboard class predicts each response
// from its own copy of the list state, and plain tasks drive the request and response channels.
// Depends on mlqm_pkg, mlqm_in_if, mlqm_out_if and the multi_list_queue_manager RTL.
`timescale 1ns / 1ps

module multi_list_queue_manager_tb;
  import mlqm_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int PHASES       = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 20;

  // One response item as the block should present it.
  typedef struct packed {
    logic                 done_res;
    logic [SLOT_IN_W-1:0] popped_slot;
  } outcome_t;

  // Tracks every list the way the block should, and holds the responses still owed.
  class list_scoreboard;
    ptr_t                 head_tab [NUM_LISTS];
    ptr_t                 tail_tab [NUM_LISTS];
    ptr_t                 next_tab [LINK_DEPTH];
    ptr_t                 prev_tab [LINK_DEPTH];
    logic [NUM_LISTS-1:0] member_tab [NUM_SLOTS];
    outcome_t             owed_q [$];
    int                   errors;
    int                   checked;
    int                   hits;
    int                   op_count [4];

    function new();
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_tab[i] = '0;
        tail_tab[i] = '0;
      end
      for (int i = 0; i < LINK_DEPTH; i++) begin
        next_tab[i] = '0;
        prev_tab[i] = '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++) member_tab[i] = '0;
      for (int i = 0; i < 4; i++) op_count[i] = 0;
      errors  = 0;
      checked = 0;
      hits    = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Returns some slot that is on list l, or -1 when the list is empty.
    function int find_member(int l);
      int start;
      int s;
      start = $urandom_range(NUM_SLOTS - 1);
      for (int k = 0; k < NUM_SLOTS; k++) begin
        s = (start + k) % NUM_SLOTS;
        if (member_tab[s][l]) return s;
      end
      return -1;
    endfunction

    // Applies one accepted request to the lists and queues the response it must produce.
    function void note_request(op_t op, logic [LIST_W-1:0] lsel, logic [SLOT_IN_W-1:0] slot);
      outcome_t res;
      int       l;
      int       s;
      int       here;
      ptr_t     me;
      ptr_t     pv;
      ptr_t     nx;
      ptr_t     h;
      res = '0;
      l = int'(lsel);
      s = int'(slot);
      op_count[int'(op)]++;
      if (l < NUM_LISTS) begin
        here = l * NUM_SLOTS + s;
        case (op)
          OP_ADD: begin
            if (s < NUM_SLOTS && !member_tab[s][l]) begin
              me = '{valid: 1'b1, idx: slot[SLOT_W-1:0]};
              next_tab[here] = '0;
              prev_tab[here] = tail_tab[l];
              if (tail_tab[l].valid) next_tab[l * NUM_SLOTS + int'(tail_tab[l].idx)] = me;
              else head_tab[l] = me;
              tail_tab[l] = me;
              member_tab[s][l] = 1'b1;
              res.done_res = 1'b1;
            end
          end
          OP_POP: begin
            h = head_tab[l];
            if (h.valid) begin
              nx = next_tab[l * NUM_SLOTS + int'(h.idx)];
              if (nx.valid) begin
                head_tab[l] = nx;
                prev_tab[l * NUM_SLOTS + int'(nx.idx)] = '0;
              end else begin
                head_tab[l] = '0;
                tail_tab[l] = '0;
              end
              member_tab[int'(h.idx)][l] = 1'b0;
              res.done_res    = 1'b1;
              res.popped_slot = SLOT_IN_W'(h.idx);
            end
          end
          OP_REMOVE: begin
            if (s < NUM_SLOTS && member_tab[s][l]) begin
              pv = prev_tab[here];
              nx = next_tab[here];
              member_tab[s][l] = 1'b0;
              if (pv.valid) next_tab[l * NUM_SLOTS + int'(pv.idx)] = nx;
              else head_tab[l] = nx;
              if (nx.valid) prev_tab[l * NUM_SLOTS + int'(nx.idx)] = pv;
              else tail_tab[l] = pv;
              res.done_res = 1'b1;
            end
          end
          default: begin
            res.done_res = head_tab[l].valid;
          end
        endcase
      end
      if (res.done_res) hits++;
      owed_q.push_back(res);
    endfunction

    // Compares one accepted response with the oldest owed one.
    function void check_response(logic done_res, logic [SLOT_IN_W-1:0] popped_slot);
      outcome_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t ns: response with none owed: done_res %0b popped_slot %0d",
                 $time, done_res, popped_slot);
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (done_res !== want.done_res) begin
        errors++;
        $display("%0t ns: done_res expected %0b actual %0b",
                 $time, want.done_res, done_res);
      end
      if (popped_slot !== want.popped_slot) begin
        errors++;
        $display("%0t ns: popped_slot expected %0d actual %0d",
                 $time, want.popped_slot, popped_slot);
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  list_scoreboard sb;
  int             send_idle_pct = 0;
  int             stall_pct = 0;
  bit             hold_req = 1'b0;
  int             hold_left = 0;
  int             quiet = 0;

  mlqm_in_if  req_if ();
  mlqm_out_if rsp_if ();

  multi_list_queue_manager DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Free-running clock, 4 ns period.
  always #2 clk = ~clk;

  // Offers one request item, after a random idle gap, and waits until it is taken.
  task automatic send_item(input op_t op, input logic [LIST_W-1:0] lsel,
                           input logic [SLOT_IN_W-1:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= op;
    req_if.list_sel   <= lsel;
    req_if.slot_index <= slot;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(op, lsel, slot);
  endtask

  // Stops offering and waits until every owed response has come back.
  task automatic wait_for_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Draws one random request, biased toward short, busy lists.
  function automatic void draw_item(output op_t op, output logic [LIST_W-1:0] lsel,
                                    output logic [SLOT_IN_W-1:0] slot);
    int pick;
    int mate;
    pick = $urandom_range(99);
    if (pick < 35) op = OP_ADD;
    else if (pick < 55) op = OP_POP;
    else if (pick < 85) op = OP_REMOVE;
    else op = OP_QUERY;
    // A few items use the selector codes past the last list.
    if ($urandom_range(99) < 5) lsel = LIST_W'($urandom_range(7, NUM_LISTS));
    else lsel = LIST_W'($urandom_range(NUM_LISTS - 1));
    // Most slots come from a small pool at both ends of the range.
    pick = $urandom_range(15);
    if ($urandom_range(99) < 15) slot = SLOT_IN_W'($urandom);
    else if (pick < 8) slot = SLOT_IN_W'(pick);
    else slot = SLOT_IN_W'(NUM_SLOTS - 16 + pick);
    // Removes mostly aim at a slot that is really on the list.
    if (op == OP_REMOVE && int'(lsel) < NUM_LISTS && $urandom_range(99) < 60) begin
      mate = sb.find_member(int'(lsel));
      if (mate >= 0) slot = SLOT_IN_W'(mate);
    end
  endfunction

  // Hand-picked items: empty lists, duplicates, removes at head, middle and tail,
  // one slot on two lists, and selectors past the last list.
  task automatic run_directed();
    send_item(OP_QUERY,  3'd0, 8'd0);
    send_item(OP_POP,    3'd0, 8'd0);
    send_item(OP_REMOVE, 3'd0, 8'd0);
    send_item(OP_ADD,    3'd0, 8'd0);
    send_item(OP_ADD,    3'd0, 8'd0);
    send_item(OP_ADD,    3'd0, 8'd255);
    send_item(OP_ADD,    3'd0, 8'h55);
    send_item(OP_ADD,    3'd0, 8'hAA);
    send_item(OP_QUERY,  3'd0, 8'd255);
    send_item(OP_REMOVE, 3'd0, 8'h55);
    send_item(OP_REMOVE, 3'd0, 8'd0);
    send_item(OP_REMOVE, 3'd0, 8'hAA);
    send_item(OP_POP,    3'd0, 8'd0);
    send_item(OP_QUERY,  3'd0, 8'd0);
    send_item(OP_ADD,    3'd4, 8'd255);
    send_item(OP_ADD,    3'd1, 8'd255);
    send_item(OP_POP,    3'd4, 8'd0);
    send_item(OP_POP,    3'd1, 8'd0);
    send_item(OP_ADD,    3'd4, 8'd7);
    send_item(OP_ADD,    3'd4, 8'd8);
    send_item(OP_POP,    3'd4, 8'd255);
    send_item(OP_REMOVE, 3'd4, 8'd8);
    send_item(OP_ADD,    3'd5, 8'd3);
    send_item(OP_QUERY,  3'd6, 8'd0);
    send_item(OP_POP,    3'd7, 8'd0);
    send_item(OP_REMOVE, 3'd7, 8'd3);
    wait_for_responses();
  endtask

  // Response side: checks each accepted item, then picks ready for the next cycle.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        sb.check_response(rsp_if.done_res, rsp_if.popped_slot);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no item moves on either channel for too long.
  initial begin
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Main sequence: reset, directed items, then random phases with different idle mixes.
  initial begin
    op_t                  op;
    logic [LIST_W-1:0]    lsel;
    logic [SLOT_IN_W-1:0] slot;
    sb = new();
    req_if.valid      = 1'b0;
    req_if.kind       = '0;
    req_if.list_sel   = '0;
    req_if.slot_index = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      // Hold the response side off for a long stretch so the block backs up.
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        draw_item(op, lsel, slot);
        send_item(op, lsel, slot);
      end
      wait_for_responses();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d adds, %0d pops, %0d removes, %0d queries; %0d reported done.",
             sb.op_count[OP_ADD], sb.op_count[OP_POP], sb.op_count[OP_REMOVE],
             sb.op_count[OP_QUERY], sb.hits);
    $display("Checked %0d responses over four idle mixes and one long output hold; %0d errors.",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
